>>> hw/rtl/btms_pkg.sv
// Shared types and constants for the button test-mode sequencer.
// No dependencies; imported by every module of the block.
package btms_pkg;

  localparam int unsigned LAMP_COUNT_DEFAULT    = 6;
  localparam int unsigned MESSAGE_COUNT_DEFAULT = 4;

  localparam int unsigned TICK_W       = 32;
  localparam int unsigned DEB_MIN_W    = 16;
  localparam int unsigned TIMEOUT_W    = 24;
  localparam int unsigned MSG_PERIOD_W = 20;
  localparam int unsigned LAMP_PERIOD_W = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 24;

  // register reset values
  localparam logic [DEB_MIN_W-1:0]     DEB_MIN_RST     = DEB_MIN_W'(10);
  localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RST     = TIMEOUT_W'(600000);
  localparam logic [MSG_PERIOD_W-1:0]  MSG_PERIOD_RST  = MSG_PERIOD_W'(10000);
  localparam logic [LAMP_PERIOD_W-1:0] LAMP_PERIOD_RST = LAMP_PERIOD_W'(500);

  // countdown reset values
  localparam logic [TIMEOUT_W-1:0]     TMO_LEFT_RST  = TIMEOUT_W'(1000);
  localparam logic [MSG_PERIOD_W-1:0]  MSG_LEFT_RST  = MSG_PERIOD_W'(5000);
  localparam logic [LAMP_PERIOD_W-1:0] LAMP_LEFT_RST = LAMP_PERIOD_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_MIN   = 2'd0,
    CFG_TEST_TIMEOUT   = 2'd1,
    CFG_MESSAGE_PERIOD = 2'd2,
    CFG_LAMP_PERIOD    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_DIODE   = 2'd1,
    MODE_DISPLAY = 2'd2
  } mode_e;

  typedef struct packed {
    logic              button_level;
    logic              shed;
    logic [TICK_W-1:0] tick_now;
  } in_item_t;

  typedef struct packed {
    logic       redisplay;
    logic [1:0] test_mode;
    logic [2:0] message_select;
    logic [2:0] lamp_index;
    logic       lamp_lit;
    logic       panel_test_flag;
    logic       start_diode_test;
    logic       clear_faults;
  } out_item_t;

  typedef struct packed {
    logic [DEB_MIN_W-1:0]     debounce_min;
    logic [TIMEOUT_W-1:0]     test_timeout;
    logic [MSG_PERIOD_W-1:0]  message_period;
    logic [LAMP_PERIOD_W-1:0] lamp_period;
  } cfg_t;

endpackage

>>> hw/rtl/btms_step.sv
// Per-poll state update: debounce counter, mode sequencing and countdowns.
// Depends on btms_pkg. State advances only when step_i is high.
module btms_step
  import btms_pkg::*;
#(
  parameter int unsigned LampCount    = LAMP_COUNT_DEFAULT,
  parameter int unsigned MessageCount = MESSAGE_COUNT_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  localparam int unsigned LampPosW = $clog2(LampCount);
  localparam int unsigned MsgIdxW  = (MessageCount > 1) ? $clog2(MessageCount) : 1;
  localparam int unsigned MselW    = MsgIdxW + 3;
  localparam int unsigned LampExtW = LampPosW + 3;

  logic                     last_level_q, last_level_d;
  logic [TICK_W-1:0]        stable_q, stable_d;
  logic [TICK_W-1:0]        saved_q, saved_d;
  logic [TICK_W-1:0]        level_tick_q, level_tick_d;
  mode_e                    mode_q, mode_d;
  logic [TIMEOUT_W-1:0]     tmo_left_q, tmo_left_d;
  logic [TICK_W-1:0]        tmo_tick_q, tmo_tick_d;
  logic [MSG_PERIOD_W-1:0]  msg_left_q, msg_left_d;
  logic [TICK_W-1:0]        msg_tick_q, msg_tick_d;
  logic [MsgIdxW-1:0]       msg_idx_q, msg_idx_d;
  logic [LAMP_PERIOD_W-1:0] lamp_left_q, lamp_left_d;
  logic [TICK_W-1:0]        lamp_tick_q, lamp_tick_d;
  logic [LampPosW-1:0]      lamp_pos_q, lamp_pos_d;
  logic                     lamp_on_q, lamp_on_d;
  logic                     test_flag_q, test_flag_d;

  logic [TICK_W-1:0] now;
  logic [TICK_W-1:0] lvl_delta, msg_delta, lamp_delta, tmo_delta;
  logic [TICK_W:0]   sum;
  logic [TICK_W-1:0] deb_min_ext;
  logic              advance;
  logic              redisplay, start_pulse, clear_pulse;
  logic [MselW-1:0]  msel_ext;
  logic [LampExtW-1:0] lamp_ext;

  assign now         = item_i.tick_now;
  assign lvl_delta   = now - level_tick_q;
  assign msg_delta   = now - msg_tick_q;
  assign lamp_delta  = now - lamp_tick_q;
  assign tmo_delta   = now - tmo_tick_q;
  assign sum         = {1'b0, stable_q} + {1'b0, lvl_delta};
  assign deb_min_ext = {{(TICK_W-DEB_MIN_W){1'b0}}, cfg_i.debounce_min};

  always_comb begin
    last_level_d = last_level_q;
    stable_d     = stable_q;
    saved_d      = saved_q;
    level_tick_d = level_tick_q;
    mode_d       = mode_q;
    tmo_left_d   = tmo_left_q;
    tmo_tick_d   = tmo_tick_q;
    msg_left_d   = msg_left_q;
    msg_tick_d   = msg_tick_q;
    msg_idx_d    = msg_idx_q;
    lamp_left_d  = lamp_left_q;
    lamp_tick_d  = lamp_tick_q;
    lamp_pos_d   = lamp_pos_q;
    lamp_on_d    = lamp_on_q;
    test_flag_d  = test_flag_q;
    advance      = 1'b0;
    redisplay    = 1'b0;
    start_pulse  = 1'b0;
    clear_pulse  = 1'b0;

    // button qualification
    if (!item_i.shed) begin
      if (item_i.button_level != last_level_q) begin
        // short glitch: restore the count from before the glitch
        if (stable_q < deb_min_ext) begin
          stable_d = saved_q;
        end else begin
          saved_d  = stable_q;
          stable_d = '0;
        end
        last_level_d = item_i.button_level;
      end else if (level_tick_q != now) begin
        if (level_tick_q < now) begin
          if ((stable_q < deb_min_ext) && (sum >= {1'b0, deb_min_ext}) &&
              item_i.button_level) begin
            advance = 1'b1;
          end
          stable_d = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
        end
        level_tick_d = now;
      end
    end

    if (advance) begin
      case (mode_q)
        MODE_IDLE: begin
          mode_d      = MODE_DIODE;
          tmo_left_d  = cfg_i.test_timeout;
          test_flag_d = 1'b1;
          start_pulse = 1'b1;
          redisplay   = 1'b1;
        end
        MODE_DIODE: begin
          mode_d      = MODE_DISPLAY;
          test_flag_d = 1'b1;
          tmo_left_d  = cfg_i.test_timeout;
          msg_left_d  = cfg_i.message_period;
          msg_idx_d   = '0;
          redisplay   = 1'b1;
        end
        default: begin
          mode_d      = MODE_IDLE;
          test_flag_d = 1'b0;
          lamp_on_d   = 1'b0;
          clear_pulse = 1'b1;
          redisplay   = 1'b1;
        end
      endcase
    end

    if (mode_d != MODE_IDLE) begin
      if (mode_d == MODE_DISPLAY) begin
        if (now > msg_tick_q) begin
          if (msg_delta > {{(TICK_W-MSG_PERIOD_W){1'b0}}, msg_left_d}) begin
            msg_left_d = cfg_i.message_period;
            msg_idx_d  = (msg_idx_d == MsgIdxW'(MessageCount - 1)) ? '0
                                                                   : msg_idx_d + MsgIdxW'(1);
            redisplay  = 1'b1;
          end else begin
            msg_left_d = msg_left_d - msg_delta[MSG_PERIOD_W-1:0];
          end
        end
        msg_tick_d = now;
      end

      if (now > lamp_tick_q) begin
        if (lamp_delta > {{(TICK_W-LAMP_PERIOD_W){1'b0}}, lamp_left_q}) begin
          lamp_left_d = cfg_i.lamp_period;
          lamp_pos_d  = (lamp_pos_q == LampPosW'(LampCount - 1)) ? '0
                                                                 : lamp_pos_q + LampPosW'(1);
          lamp_on_d   = 1'b1;
        end else begin
          lamp_left_d = lamp_left_q - lamp_delta[LAMP_PERIOD_W-1:0];
        end
      end
      lamp_tick_d = now;

      // timeout expiry leaves the countdown stale; it reloads on mode entry
      if (now > tmo_tick_q) begin
        if (tmo_delta > {{(TICK_W-TIMEOUT_W){1'b0}}, tmo_left_d}) begin
          mode_d      = MODE_IDLE;
          test_flag_d = 1'b0;
          lamp_on_d   = 1'b0;
          clear_pulse = 1'b1;
          redisplay   = 1'b1;
        end else begin
          tmo_left_d = tmo_left_d - tmo_delta[TIMEOUT_W-1:0];
        end
      end
      tmo_tick_d = now;
    end
  end

  assign msel_ext = {3'b000, msg_idx_d} + MselW'(1);
  assign lamp_ext = {3'b000, lamp_pos_d};

  always_comb begin
    result_o.redisplay        = redisplay;
    result_o.test_mode        = mode_d;
    result_o.message_select   = (mode_d == MODE_DISPLAY) ? msel_ext[2:0] : 3'b000;
    result_o.lamp_index       = lamp_ext[2:0];
    result_o.lamp_lit         = lamp_on_d;
    result_o.panel_test_flag  = test_flag_d;
    result_o.start_diode_test = start_pulse;
    result_o.clear_faults     = clear_pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      stable_q     <= '0;
      saved_q      <= '0;
      level_tick_q <= '0;
      mode_q       <= MODE_IDLE;
      tmo_left_q   <= TMO_LEFT_RST;
      tmo_tick_q   <= '0;
      msg_left_q   <= MSG_LEFT_RST;
      msg_tick_q   <= '0;
      msg_idx_q    <= '0;
      lamp_left_q  <= LAMP_LEFT_RST;
      lamp_tick_q  <= '0;
      lamp_pos_q   <= '0;
      lamp_on_q    <= 1'b0;
      test_flag_q  <= 1'b0;
    end else if (step_i) begin
      last_level_q <= last_level_d;
      stable_q     <= stable_d;
      saved_q      <= saved_d;
      level_tick_q <= level_tick_d;
      mode_q       <= mode_d;
      tmo_left_q   <= tmo_left_d;
      tmo_tick_q   <= tmo_tick_d;
      msg_left_q   <= msg_left_d;
      msg_tick_q   <= msg_tick_d;
      msg_idx_q    <= msg_idx_d;
      lamp_left_q  <= lamp_left_d;
      lamp_tick_q  <= lamp_tick_d;
      lamp_pos_q   <= lamp_pos_d;
      lamp_on_q    <= lamp_on_d;
      test_flag_q  <= test_flag_d;
    end
  end

endmodule

>>> hw/rtl/button_test_mode_sequencer_top.sv
// Top level of the button test-mode sequencer: poll register, result register
// and configuration registers. Depends on btms_pkg and btms_step.

// One poll beat in gives one result beat out. A poll is captured in an input
// register; once the result register can take a beat, the whole state update
// (debounce counter, mode step, lamp/message/timeout countdowns) is done in one
// pass in btms_step and lands in the result register. A new poll is taken
// every cycle while the result side keeps up. The state update is the only
// loop, which is what sets the one-beat-per-cycle rate. Configuration writes
// are always taken (cfg_ready_o is tied high) and should only be issued while
// no poll is in flight.
module button_test_mode_sequencer_top
  import btms_pkg::*;
#(
  parameter int unsigned LampCount    = LAMP_COUNT_DEFAULT,
  parameter int unsigned MessageCount = MESSAGE_COUNT_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_item_t out_q;
  logic      out_vld_q, out_vld_d;
  cfg_t      cfg_q;
  out_item_t result;
  logic      step;
  logic      in_take;

  assign step        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !step;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_min   <= DEB_MIN_RST;
      cfg_q.test_timeout   <= TIMEOUT_RST;
      cfg_q.message_period <= MSG_PERIOD_RST;
      cfg_q.lamp_period    <= LAMP_PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE_MIN:   cfg_q.debounce_min   <= cfg_data_i[DEB_MIN_W-1:0];
        CFG_TEST_TIMEOUT:   cfg_q.test_timeout   <= cfg_data_i[TIMEOUT_W-1:0];
        CFG_MESSAGE_PERIOD: cfg_q.message_period <= cfg_data_i[MSG_PERIOD_W-1:0];
        CFG_LAMP_PERIOD:    cfg_q.lamp_period    <= cfg_data_i[LAMP_PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  btms_step #(
    .LampCount    (LampCount),
    .MessageCount (MessageCount)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/btms_checker.sv
// Port-level checks for the button test-mode sequencer, bound to the top.
// Depends on btms_pkg and button_test_mode_sequencer_top.
module btms_checker
  import btms_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a stale timeout tick can expire the fresh diode test in the same poll
  a_start_in_diode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.start_diode_test |->
      out_data_o.redisplay &&
      (out_data_o.test_mode == MODE_DIODE || out_data_o.clear_faults))
    else $error("diode test start outside diode mode");

  a_clear_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clear_faults |->
      out_data_o.test_mode == MODE_IDLE && !out_data_o.panel_test_flag &&
      !out_data_o.lamp_lit && out_data_o.redisplay)
    else $error("fault clear without return to idle");

  a_msg_only_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.test_mode != MODE_DISPLAY |->
      out_data_o.message_select == 3'b000)
    else $error("message selected outside display test");

  a_flag_follows_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.panel_test_flag == (out_data_o.test_mode != MODE_IDLE))
    else $error("panel test flag disagrees with mode");

endmodule

bind button_test_mode_sequencer_top btms_checker u_btms_checker (.*);

>>> bench/button_test_mode_sequencer_top_tb.sv
// Self-checking bench for button_test_mode_sequencer_top: directed polls, then random press
// sequences over several register settings, checked beat by beat against a shadow model.
// Depends on btms_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module button_test_mode_sequencer_top_tb;
  import btms_pkg::*;

  localparam int unsigned LIMIT = 400000;

  // Shadow of the sequencer state; one expected beat per accepted poll.
  class sequencer_shadow;
    logic [DEB_MIN_W-1:0]     press_ticks;
    logic [TIMEOUT_W-1:0]     quit_ticks;
    logic [MSG_PERIOD_W-1:0]  msg_ticks;
    logic [LAMP_PERIOD_W-1:0] chase_ticks;

    logic               held_level;
    logic [31:0]        steady_ticks, parked_ticks, level_seen;
    mode_e              cur_mode;
    logic signed [32:0] quit_budget, msg_budget, chase_budget;
    logic [31:0]        quit_seen, msg_seen, chase_seen;
    logic [1:0]         msg_slot;
    logic [2:0]         chase_lamp;
    logic               chase_lit, testing;

    out_item_t beat;
    out_item_t due_beats[$];
    int unsigned errors;

    function void power_on();
      press_ticks  = DEB_MIN_RST;
      quit_ticks   = TIMEOUT_RST;
      msg_ticks    = MSG_PERIOD_RST;
      chase_ticks  = LAMP_PERIOD_RST;
      held_level   = 1'b0;
      steady_ticks = '0;
      parked_ticks = '0;
      level_seen   = '0;
      cur_mode     = MODE_IDLE;
      quit_budget  = {9'b0, TMO_LEFT_RST};
      msg_budget   = {13'b0, MSG_LEFT_RST};
      chase_budget = {17'b0, LAMP_LEFT_RST};
      quit_seen    = '0;
      msg_seen     = '0;
      chase_seen   = '0;
      msg_slot     = '0;
      chase_lamp   = '0;
      chase_lit    = 1'b0;
      testing      = 1'b0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DEBOUNCE_MIN:   press_ticks = val[DEB_MIN_W-1:0];
        CFG_TEST_TIMEOUT:   quit_ticks  = val[TIMEOUT_W-1:0];
        CFG_MESSAGE_PERIOD: msg_ticks   = val[MSG_PERIOD_W-1:0];
        default:            chase_ticks = val[LAMP_PERIOD_W-1:0];
      endcase
    endfunction

    function logic signed [32:0] elapsed(logic [31:0] now, logic [31:0] seen);
      return {1'b0, now - seen};
    endfunction

    function void drop_to_idle();
      cur_mode = MODE_IDLE;
      testing = 1'b0;
      chase_lit = 1'b0;
      beat.clear_faults = 1'b1;
      beat.redisplay = 1'b1;
    endfunction

    function void step_mode();
      case (cur_mode)
        MODE_IDLE: begin
          cur_mode = MODE_DIODE;
          quit_budget = {9'b0, quit_ticks};
          testing = 1'b1;
          beat.start_diode_test = 1'b1;
          beat.redisplay = 1'b1;
        end
        MODE_DIODE: begin
          cur_mode = MODE_DISPLAY;
          testing = 1'b1;
          quit_budget = {9'b0, quit_ticks};
          msg_budget = {13'b0, msg_ticks};
          msg_slot = '0;
          beat.redisplay = 1'b1;
        end
        default: drop_to_idle();
      endcase
    endfunction

    function void take_poll(in_item_t p);
      logic [32:0] sum;
      beat = '0;
      if (!p.shed) begin
        if (p.button_level != held_level) begin
          // edge: a short run is treated as a bounce and the old count comes back
          if (steady_ticks < press_ticks) begin
            steady_ticks = parked_ticks;
          end else begin
            parked_ticks = steady_ticks;
            steady_ticks = '0;
          end
          held_level = p.button_level;
        end else if (level_seen != p.tick_now) begin
          if (level_seen < p.tick_now) begin
            sum = {1'b0, steady_ticks} + {1'b0, p.tick_now - level_seen};
            if (steady_ticks < press_ticks && sum >= press_ticks && p.button_level)
              step_mode();
            steady_ticks = sum[32] ? '1 : sum[31:0];
          end
          level_seen = p.tick_now;
        end
      end

      if (cur_mode != MODE_IDLE) begin
        if (cur_mode == MODE_DISPLAY) begin
          if (p.tick_now > msg_seen) begin
            msg_budget = msg_budget - elapsed(p.tick_now, msg_seen);
            if (msg_budget < 0) begin
              msg_budget = {13'b0, msg_ticks};
              msg_slot = 2'((msg_slot + 1) % MESSAGE_COUNT_DEFAULT);
              beat.redisplay = 1'b1;
            end
          end
          msg_seen = p.tick_now;
        end
        if (p.tick_now > chase_seen) begin
          chase_budget = chase_budget - elapsed(p.tick_now, chase_seen);
          if (chase_budget < 0) begin
            chase_budget = {17'b0, chase_ticks};
            chase_lamp = 3'((chase_lamp + 1) % LAMP_COUNT_DEFAULT);
            chase_lit = 1'b1;
          end
        end
        chase_seen = p.tick_now;
        if (p.tick_now > quit_seen) begin
          quit_budget = quit_budget - elapsed(p.tick_now, quit_seen);
          if (quit_budget < 0) drop_to_idle();
        end
        quit_seen = p.tick_now;
      end

      beat.test_mode = cur_mode;
      beat.message_select = (cur_mode == MODE_DISPLAY) ? 3'({1'b0, msg_slot} + 3'd1) : 3'd0;
      beat.lamp_index = chase_lamp;
      beat.lamp_lit = chase_lit;
      beat.panel_test_flag = testing;
      due_beats.push_back(beat);
    endfunction

    function void field_check(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (due_beats.size() == 0) begin
        $error("result beat with nothing pending: %p", got);
        errors++;
        return;
      end
      want = due_beats.pop_front();
      field_check("redisplay", want.redisplay, got.redisplay);
      field_check("test_mode", want.test_mode, got.test_mode);
      field_check("message_select", want.message_select, got.message_select);
      field_check("lamp_index", want.lamp_index, got.lamp_index);
      field_check("lamp_lit", want.lamp_lit, got.lamp_lit);
      field_check("panel_test_flag", want.panel_test_flag, got.panel_test_flag);
      field_check("start_diode_test", want.start_diode_test, got.start_diode_test);
      field_check("clear_faults", want.clear_faults, got.clear_faults);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sequencer_shadow board;
  int unsigned     idle_pct = 38;
  int unsigned     cycles = 0;
  logic [31:0]     tick_clock = '0;
  logic            drive_level = 1'b0;

  always #1 clk = ~clk;

  button_test_mode_sequencer_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("button_test_mode_sequencer_top_tb: done, errors");
      $finish;
    end
  end

  // result side: check the beat taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.match_result(out_data);
    out_stall <= ($urandom_range(0, 99) < idle_pct);
  end

  task automatic send_poll(logic lvl, logic shd, logic [31:0] tk);
    in_item_t poll;
    poll.button_level = lvl;
    poll.shed = shd;
    poll.tick_now = tk;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= poll;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_poll(poll);
  endtask

  task automatic drain();
    while (board.due_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic run_phase(logic [15:0] deb, logic [23:0] quit, logic [19:0] msg,
                           logic [15:0] chase, int unsigned step, int unsigned count);
    int unsigned sent, roll, polls;
    logic shed_now, jump;
    drain();
    load_reg(CFG_DEBOUNCE_MIN, CFG_DATA_W'(deb));
    load_reg(CFG_TEST_TIMEOUT, CFG_DATA_W'(quit));
    load_reg(CFG_MESSAGE_PERIOD, CFG_DATA_W'(msg));
    load_reg(CFG_LAMP_PERIOD, CFG_DATA_W'(chase));
    cfg_valid <= 1'b0;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      shed_now = 1'b0;
      jump = 1'b0;
      polls = $urandom_range(2, 6);
      if (roll < 62) begin
        // normal press or release held for a few polls
        drive_level = ~drive_level;
      end else if (roll < 70) begin
        polls = $urandom_range(10, 40);
      end else if (roll < 78) begin
        drive_level = ~drive_level;
        polls = 1;
      end else if (roll < 86) begin
        shed_now = 1'b1;
      end else if (roll < 92) begin
        tick_clock = tick_clock - $urandom_range(0, 4 * step);
        polls = 1;
      end else begin
        jump = 1'b1;
        polls = 1;
        if (roll >= 96) begin
          drive_level = 1'($urandom_range(0, 1));
          shed_now = 1'($urandom_range(0, 1));
        end
      end
      for (int i = 0; i < polls; i++) begin
        if (jump) tick_clock = $urandom;
        else tick_clock = tick_clock + $urandom_range(0, step);
        if (shed_now) drive_level = 1'($urandom_range(0, 1));
        send_poll(drive_level, shed_now, tick_clock);
      end
      sent += polls;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] d;
    board = new;
    board.power_on();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: counter saturation, tick going backwards, bounces
    send_poll(1'b0, 1'b0, 32'd0);
    send_poll(1'b0, 1'b0, 32'd5);
    send_poll(1'b0, 1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 1'b0, 32'd0);
    send_poll(1'b0, 1'b0, 32'hFFFF_FFFF);
    send_poll(1'b1, 1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 1'b0, 32'd40);
    send_poll(1'b1, 1'b0, 32'd100);
    send_poll(1'b1, 1'b0, 32'd50);
    send_poll(1'b1, 1'b0, 32'd60);
    // diode test entered; shed poll still runs the chase
    send_poll(1'b0, 1'b1, 32'd700);
    send_poll(1'b0, 1'b0, 32'd710);
    send_poll(1'b0, 1'b0, 32'd730);
    send_poll(1'b1, 1'b0, 32'd740);
    send_poll(1'b1, 1'b0, 32'd760);
    send_poll(1'b1, 1'b0, 32'd12000);
    send_poll(1'b0, 1'b0, 32'd12005);
    send_poll(1'b0, 1'b0, 32'd12020);
    send_poll(1'b1, 1'b0, 32'd12030);
    send_poll(1'b1, 1'b0, 32'd12040);
    // back in idle; enter diode test again and let the timeout fire
    send_poll(1'b0, 1'b0, 32'd12050);
    send_poll(1'b0, 1'b0, 32'd12070);
    send_poll(1'b1, 1'b0, 32'd12080);
    send_poll(1'b1, 1'b0, 32'd12095);
    send_poll(1'b1, 1'b1, 32'hFFFF_FFF0);
    in_valid <= 1'b0;
    drive_level = 1'b1;
    tick_clock = 32'd20000;

    run_phase(16'd4, 24'd400, 20'd60, 16'd20, 10, 240);
    run_phase(16'd1, 24'd0, 20'd0, 16'd0, 3, 240);
    run_phase(16'd65535, 24'd16777215, 20'd1048575, 16'd65535, 150000, 240);
    idle_pct = 0;
    run_phase(16'd12, 24'd1500, 20'd200, 16'd0, 20, 300);
    idle_pct = 38;
    d = 16'($urandom_range(1, 40));
    run_phase(d, 24'($urandom_range(100, 3000)), 20'($urandom_range(0, 400)),
              16'($urandom_range(0, 80)), 3 * d + 2, 240);
    run_phase(16'd8, 24'd16777215, 20'd30, 16'd65535, 12, 240);
    d = 16'($urandom_range(1, 40));
    run_phase(d, 24'($urandom_range(50, 2000)), 20'($urandom_range(0, 300)),
              16'($urandom_range(0, 60)), 2 * d + 3, 200);
    run_phase(16'd3, 24'd200, 20'd1048575, 16'd5, 8, 230);

    drain();
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("button_test_mode_sequencer_top_tb: done, clean");
    end else begin
      $display("button_test_mode_sequencer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
